// ===== hdl/ptp_pkg.sv =====
// Shared types, constants and helper functions for the propeller thrust and power model.
// Used by ptp_mul, ptp_div and propeller_thrust_power_model; depends on nothing else.
`default_nettype none
package ptp_pkg;

  localparam int POLY_TERMS_DEFAULT = 4;

  localparam int MUL_W   = 64;
  localparam int PROD_W  = 128;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_SH_MAX = 16;
  localparam int DIV_Q_W = DIV_NUM_W + DIV_SH_MAX;
  localparam int DIV_DEN_W = 48;
  localparam int MAG_W   = 63;

  localparam logic [DIV_DEN_W-1:0] TWO_PI_Q16 = 48'd411775;
  localparam logic [39:0]          HZ_MIN_Q16 = 40'd6554;
  localparam logic [MAG_W-1:0]     MAG_LIM    = 63'h4000_0000_0000_0000;

  // Last chain step of the hz factors and of the diameter factors in the thrust and power chains.
  localparam logic [3:0] CHAIN_T_HZ_END = 4'd2;
  localparam logic [3:0] CHAIN_T_D_END  = 4'd6;
  localparam logic [3:0] CHAIN_P_HZ_END = 4'd3;
  localparam logic [3:0] CHAIN_P_D_END  = 4'd8;

  localparam logic [2:0] CFG_THRUST_COEFS = 3'd0;
  localparam logic [2:0] CFG_POWER_COEFS  = 3'd1;
  localparam logic [2:0] CFG_PROP_DIAM    = 3'd2;
  localparam logic [2:0] CFG_MAX_ADV      = 3'd3;
  localparam logic [2:0] CFG_EFFICIENCY   = 3'd4;
  localparam logic [2:0] CFG_SLOWDOWN     = 3'd5;
  localparam logic [2:0] CFG_DIRECTION    = 3'd6;
  localparam logic [2:0] CFG_AIR_DENSITY  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_W,
    ST_HZ,
    ST_DOT,
    ST_DEN,
    ST_J,
    ST_POLY,
    ST_CHAIN,
    ST_TQ,
    ST_PW,
    ST_DONE
  } ptp_state_t;

  // Product shifted right by 12 or 16 and clamped at 2^62.
  function automatic logic [MAG_W-1:0] sat62(input logic [PROD_W-1:0] prod,
                                             input logic sh12);
    logic [PROD_W-1:0] s;
    begin
      s = sh12 ? (prod >> 12) : (prod >> 16);
      sat62 = (s > PROD_W'(MAG_LIM)) ? MAG_LIM : s[MAG_W-1:0];
    end
  endfunction

  // Signed 32-bit saturation of a sign and a magnitude.
  function automatic logic [31:0] sat32(input logic neg, input logic [MAG_W-1:0] mag);
    begin
      if (!neg) begin
        sat32 = (mag > 63'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
      end else if (mag > 63'h8000_0000) begin
        sat32 = 32'h8000_0000;
      end else begin
        sat32 = 32'(-mag[31:0]);
      end
    end
  endfunction

  function automatic logic signed [15:0] coef_at(input logic [63:0] packed_c,
                                                 input logic [1:0] idx);
    begin
      coef_at = $signed(packed_c[16*idx +: 16]);
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/propeller_thrust_power_model.sv =====
// Propeller thrust and power model top level (sequencer, registers, datapath); uses ptp_pkg,
// ptp_mul and ptp_div. One item at a time: in_stall stays high from the input transfer until
// the result enters the output register, so a new item is not taken before the last is done.
// Synchronous active-high reset restores register defaults and clears the held power.
`default_nettype none
module propeller_thrust_power_model #(
  parameter int POLY_TERMS = ptp_pkg::POLY_TERMS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Input item channel.
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] joint_speed,
  input  wire logic signed [31:0] body_vel_x,
  input  wire logic signed [31:0] body_vel_y,
  input  wire logic signed [31:0] body_vel_z,
  input  wire logic signed [31:0] wind_x,
  input  wire logic signed [31:0] wind_y,
  input  wire logic signed [31:0] wind_z,
  input  wire logic signed [15:0] axis_x,
  input  wire logic signed [15:0] axis_y,
  input  wire logic signed [15:0] axis_z,
  // Result channel.
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      thrust,
  output logic signed [31:0]      rotor_torque,
  output logic signed [31:0]      power,
  output logic                    spinning,
  // Configuration write channel.
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);

  localparam int PCNT_W = $clog2(POLY_TERMS + 1);
  localparam logic [PCNT_W-1:0] POLY_STEPS = PCNT_W'(POLY_TERMS - 1);
  localparam logic [1:0] TOP_IDX = 2'(POLY_TERMS - 1);

  // Configuration registers.
  logic [63:0]       thrust_coefs;
  logic [63:0]       power_coefs;
  logic [23:0]       prop_diameter;
  logic [15:0]       max_advance_ratio;
  logic [15:0]       efficiency;
  logic [9:0]        slowdown;
  logic signed [1:0] rotor_dir;
  logic [15:0]       air_density;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thrust_coefs      <= '0;
      power_coefs       <= '0;
      prop_diameter     <= 24'd16646;
      max_advance_ratio <= 16'd6144;
      efficiency        <= 16'd24576;
      slowdown          <= 10'd10;
      rotor_dir         <= 2'sb01;
      air_density       <= 16'd5018;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ptp_pkg::CFG_THRUST_COEFS: thrust_coefs      <= cfg_data;
        ptp_pkg::CFG_POWER_COEFS:  power_coefs       <= cfg_data;
        ptp_pkg::CFG_PROP_DIAM:    prop_diameter     <= cfg_data[23:0];
        ptp_pkg::CFG_MAX_ADV:      max_advance_ratio <= cfg_data[15:0];
        ptp_pkg::CFG_EFFICIENCY:   efficiency        <= cfg_data[15:0];
        ptp_pkg::CFG_SLOWDOWN:     slowdown          <= cfg_data[9:0];
        ptp_pkg::CFG_DIRECTION:    rotor_dir         <= $signed(cfg_data[1:0]);
        ptp_pkg::CFG_AIR_DENSITY:  air_density       <= cfg_data[15:0];
        default:                   thrust_coefs      <= thrust_coefs;
      endcase
    end
  end

  ptp_pkg::ptp_state_t state, state_next;
  logic in_accept;
  logic out_load;
  logic op_issued, op_issued_next;

  assign in_stall  = (state != ptp_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == ptp_pkg::ST_DONE) && (!out_valid || !out_stall);

  // Item registers. The relative wind is formed once at the input transfer and kept as a
  // magnitude and a sign, so the shared multiplier only ever sees unsigned operands.
  logic [31:0] js_abs;
  logic [32:0] rel_abs [3];
  logic [15:0] ax_abs  [3];
  logic        term_neg [3];

  // Working registers.
  logic [40:0]        w;
  logic [39:0]        hz;
  logic signed [53:0] dot;
  logic [1:0]         k;
  logic [47:0]        den;
  logic [15:0]        j;
  logic signed [39:0] c;
  logic signed [39:0] ct;
  logic signed [39:0] cp;
  logic [PCNT_W-1:0]  pcnt;
  logic               poly_pwr;
  logic [62:0]        val;
  logic [3:0]         cstep;
  logic               chain_pwr;
  logic [62:0]        t_mag;
  logic [62:0]        p_mag;
  logic [62:0]        tq_mag;
  logic [31:0]        last_power;

  logic [31:0] res_thrust;
  logic [31:0] res_torque;
  logic [31:0] res_power;
  logic        res_spin;

  // Shared units.
  logic                          mul_start, mul_done;
  logic [ptp_pkg::MUL_W-1:0]     mul_a, mul_b;
  logic [ptp_pkg::PROD_W-1:0]    mul_prod;
  logic                          div_start, div_done;
  logic [ptp_pkg::DIV_NUM_W-1:0] div_num;
  logic [4:0]                    div_sh;
  logic [ptp_pkg::DIV_DEN_W-1:0] div_den;
  logic [ptp_pkg::DIV_Q_W-1:0]   div_quo;

  ptp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  ptp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .sh    (div_sh),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Chain operand selection: density first, then the hz factors, then the diameter factors.
  logic [3:0]  hz_end, d_end;
  logic        chain_sh12;
  logic [39:0] chain_b;
  logic [62:0] chain_res;
  logic [62:0] p_start;

  assign hz_end     = chain_pwr ? ptp_pkg::CHAIN_P_HZ_END : ptp_pkg::CHAIN_T_HZ_END;
  assign d_end      = chain_pwr ? ptp_pkg::CHAIN_P_D_END : ptp_pkg::CHAIN_T_D_END;
  assign chain_sh12 = (cstep == 4'd0);
  assign chain_b    = (cstep == 4'd0) ? 40'(air_density) :
                      (cstep <= hz_end) ? hz : 40'(prop_diameter);
  assign chain_res  = ptp_pkg::sat62(mul_prod, chain_sh12);

  // Polynomial step: c = floor(c * j / 2^12) + coef, the product taken as a magnitude.
  logic [39:0]        c_abs;
  logic [PCNT_W-1:0]  pcnt_m1;
  logic signed [15:0] coef_cur;
  logic signed [63:0] ps;
  logic signed [39:0] c_step;

  assign c_abs    = c[39] ? 40'(-c) : c;
  assign pcnt_m1  = pcnt - 1'b1;
  assign coef_cur = ptp_pkg::coef_at(poly_pwr ? power_coefs : thrust_coefs, pcnt_m1[1:0]);
  assign ps       = c[39] ? -$signed(mul_prod[63:0]) : $signed(mul_prod[63:0]);
  assign c_step   = 40'(ps >>> 12) + 40'(coef_cur);

  logic [39:0] ct_abs, cp_abs;
  assign ct_abs  = ct[39] ? 40'(-ct) : ct;
  assign cp_abs  = cp[39] ? 40'(-cp) : cp;
  assign p_start = 63'(cp_abs) << 4;

  logic signed [53:0] dot_term;
  logic [53:0]        dot_abs;
  assign dot_term = term_neg[k] ? -$signed({6'd0, mul_prod[47:0]})
                                : $signed({6'd0, mul_prod[47:0]});
  assign dot_abs  = dot[53] ? 54'(-dot) : dot;

  logic [62:0] q_sat;
  assign q_sat = (div_quo > ptp_pkg::DIV_Q_W'(ptp_pkg::MAG_LIM)) ? ptp_pkg::MAG_LIM
                                                                  : div_quo[62:0];

  // Sequencer: each arithmetic state starts its unit once per operation and waits for the done pulse.
  always_comb begin
    state_next     = state;
    op_issued_next = op_issued;
    mul_start      = 1'b0;
    div_start      = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    div_num        = '0;
    div_sh         = 5'd16;
    div_den        = '0;
    unique case (state)
      ptp_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = ptp_pkg::ST_W;
        end
      end
      ptp_pkg::ST_W: begin
        mul_a = 64'(js_abs);
        mul_b = 64'(slowdown);
      end
      ptp_pkg::ST_HZ: begin
        div_num = 64'(w);
        div_sh  = 5'd16;
        div_den = ptp_pkg::TWO_PI_Q16;
      end
      ptp_pkg::ST_DOT: begin
        mul_a = 64'(rel_abs[k]);
        mul_b = 64'(ax_abs[k]);
      end
      ptp_pkg::ST_DEN: begin
        mul_a = 64'(hz);
        mul_b = 64'(prop_diameter);
      end
      ptp_pkg::ST_J: begin
        div_num = 64'(dot_abs >> 14);
        div_sh  = 5'd12;
        div_den = den;
      end
      ptp_pkg::ST_POLY: begin
        mul_a = 64'(c_abs);
        mul_b = 64'(j);
      end
      ptp_pkg::ST_CHAIN: begin
        mul_a = 64'(val);
        mul_b = 64'(chain_b);
      end
      ptp_pkg::ST_TQ: begin
        div_num = 64'(p_mag);
        div_sh  = 5'd16;
        div_den = 48'(w);
      end
      ptp_pkg::ST_PW: begin
        div_num = 64'(p_mag);
        div_sh  = 5'd15;
        div_den = 48'(efficiency);
      end
      ptp_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = ptp_pkg::ST_IDLE;
        end
      end
      default: state_next = ptp_pkg::ST_IDLE;
    endcase

    unique case (state)
      ptp_pkg::ST_W, ptp_pkg::ST_DOT, ptp_pkg::ST_DEN, ptp_pkg::ST_CHAIN: begin
        if (!op_issued) begin
          mul_start      = 1'b1;
          op_issued_next = 1'b1;
        end else if (mul_done) begin
          op_issued_next = 1'b0;
          unique case (state)
            ptp_pkg::ST_W:   state_next = ptp_pkg::ST_HZ;
            ptp_pkg::ST_DOT: state_next = (k == 2'd2) ? ptp_pkg::ST_DEN : ptp_pkg::ST_DOT;
            ptp_pkg::ST_DEN: state_next = ptp_pkg::ST_J;
            default: begin
              if (cstep == d_end && chain_pwr) begin
                state_next = ptp_pkg::ST_TQ;
              end
            end
          endcase
        end
      end
      ptp_pkg::ST_POLY: begin
        // With no steps left the polynomial is finished and no product is started.
        if (pcnt == '0) begin
          if (poly_pwr) begin
            state_next = ptp_pkg::ST_CHAIN;
          end
        end else if (!op_issued) begin
          mul_start      = 1'b1;
          op_issued_next = 1'b1;
        end else if (mul_done) begin
          op_issued_next = 1'b0;
        end
      end
      ptp_pkg::ST_HZ, ptp_pkg::ST_J, ptp_pkg::ST_TQ, ptp_pkg::ST_PW: begin
        if (!op_issued) begin
          div_start      = 1'b1;
          op_issued_next = 1'b1;
        end else if (div_done) begin
          op_issued_next = 1'b0;
          unique case (state)
            ptp_pkg::ST_HZ: begin
              state_next = (40'(div_quo) <= ptp_pkg::HZ_MIN_Q16) ? ptp_pkg::ST_DONE
                                                                  : ptp_pkg::ST_DOT;
            end
            ptp_pkg::ST_J:  state_next = ptp_pkg::ST_POLY;
            ptp_pkg::ST_TQ: state_next = ptp_pkg::ST_PW;
            default:        state_next = ptp_pkg::ST_DONE;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptp_pkg::ST_IDLE;
      op_issued <= 1'b0;
    end else begin
      state     <= state_next;
      op_issued <= op_issued_next;
    end
  end

  // Datapath updates: input capture, one update per completed unit operation, and polynomial hand-overs.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_power <= '0;
    end else begin
      if (in_accept) begin
        js_abs      <= joint_speed[31] ? 32'(-joint_speed) : joint_speed;
        rel_abs[1]  <= ($signed(33'(body_vel_y)) < $signed(33'(wind_y))) ?
                       33'($signed(33'(wind_y)) - $signed(33'(body_vel_y))) :
                       33'($signed(33'(body_vel_y)) - $signed(33'(wind_y)));
        rel_abs[2]  <= ($signed(33'(body_vel_z)) < $signed(33'(wind_z))) ?
                       33'($signed(33'(wind_z)) - $signed(33'(body_vel_z))) :
                       33'($signed(33'(body_vel_z)) - $signed(33'(wind_z)));
        rel_abs[0]  <= (body_vel_x < wind_x) ?
                       33'($signed({wind_x[31], wind_x}) - $signed({body_vel_x[31], body_vel_x})) :
                       33'($signed({body_vel_x[31], body_vel_x}) - $signed({wind_x[31], wind_x}));
        ax_abs[0]   <= axis_x[15] ? 16'(-axis_x) : axis_x;
        ax_abs[1]   <= axis_y[15] ? 16'(-axis_y) : axis_y;
        ax_abs[2]   <= axis_z[15] ? 16'(-axis_z) : axis_z;
        term_neg[0] <= (body_vel_x < wind_x) != axis_x[15];
        term_neg[1] <= (body_vel_y < wind_y) != axis_y[15];
        term_neg[2] <= (body_vel_z < wind_z) != axis_z[15];
        dot         <= '0;
        k           <= '0;
      end

      unique case (state)
        ptp_pkg::ST_W: begin
          if (op_issued && mul_done) begin
            w <= 41'(mul_prod);
          end
        end
        ptp_pkg::ST_HZ: begin
          if (op_issued && div_done) begin
            hz <= 40'(div_quo);
            // Idle rotor: zero thrust and torque, power held.
            res_thrust <= '0;
            res_torque <= '0;
            res_power  <= last_power;
            res_spin   <= 1'b0;
          end
        end
        ptp_pkg::ST_DOT: begin
          if (op_issued && mul_done) begin
            dot <= dot + dot_term;
            k   <= k + 2'd1;
          end
        end
        ptp_pkg::ST_DEN: begin
          if (op_issued && mul_done) begin
            den <= 48'(mul_prod >> 16);
          end
        end
        ptp_pkg::ST_J: begin
          if (op_issued && div_done) begin
            // A zero denominator yields an all-ones quotient, which clamps as required.
            j <= (div_quo > ptp_pkg::DIV_Q_W'(max_advance_ratio)) ? max_advance_ratio
                                                                  : div_quo[15:0];
            c        <= 40'(ptp_pkg::coef_at(thrust_coefs, TOP_IDX));
            pcnt     <= POLY_STEPS;
            poly_pwr <= 1'b0;
          end
        end
        ptp_pkg::ST_POLY: begin
          if (pcnt == '0) begin
            if (!poly_pwr) begin
              ct       <= c;
              c        <= 40'(ptp_pkg::coef_at(power_coefs, TOP_IDX));
              pcnt     <= POLY_STEPS;
              poly_pwr <= 1'b1;
            end else begin
              cp        <= c;
              val       <= 63'(ct_abs) << 4;
              cstep     <= '0;
              chain_pwr <= 1'b0;
            end
          end else if (op_issued && mul_done) begin
            c    <= c_step;
            pcnt <= pcnt_m1;
          end
        end
        ptp_pkg::ST_CHAIN: begin
          if (op_issued && mul_done) begin
            if (cstep == d_end) begin
              if (!chain_pwr) begin
                t_mag     <= chain_res;
                val       <= p_start;
                cstep     <= '0;
                chain_pwr <= 1'b1;
              end else begin
                p_mag <= chain_res;
              end
            end else begin
              val   <= chain_res;
              cstep <= cstep + 4'd1;
            end
          end
        end
        ptp_pkg::ST_TQ: begin
          if (op_issued && div_done) begin
            tq_mag <= q_sat;
          end
        end
        ptp_pkg::ST_PW: begin
          if (op_issued && div_done) begin
            res_thrust <= ptp_pkg::sat32(ct[39], t_mag);
            if (rotor_dir == 2'sb00) begin
              res_torque <= '0;
            end else begin
              res_torque <= ptp_pkg::sat32(!rotor_dir[1] != cp[39], tq_mag);
            end
            // A zero efficiency also gives an all-ones quotient and so saturates.
            res_power  <= ptp_pkg::sat32(cp[39], q_sat);
            last_power <= ptp_pkg::sat32(cp[39], q_sat);
            res_spin   <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: the result is held until the downstream side takes the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid    <= 1'b1;
        thrust       <= res_thrust;
        rotor_torque <= res_torque;
        power        <= res_power;
        spinning     <= res_spin;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ptp_mul.sv =====
// Shared 64x64 unsigned multiplier built from four registered 32x32 partial products.
// Depends on ptp_pkg for widths.
`default_nettype none
module ptp_mul (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ptp_pkg::MUL_W-1:0]     a,
  input  wire logic [ptp_pkg::MUL_W-1:0]     b,
  output logic                               done,
  output logic [ptp_pkg::PROD_W-1:0]         prod
);

  logic [ptp_pkg::MUL_W-1:0] a_reg;
  logic [ptp_pkg::MUL_W-1:0] b_reg;
  logic [2:0]                cnt;
  logic                      busy;
  logic [63:0]               pp;
  logic                      pp_valid;
  logic [1:0]                pp_off;
  logic [31:0]               a_half;
  logic [31:0]               b_half;
  logic [ptp_pkg::PROD_W-1:0] pp_shifted;

  assign a_half = cnt[0] ? a_reg[63:32] : a_reg[31:0];
  assign b_half = cnt[1] ? b_reg[63:32] : b_reg[31:0];

  always_comb begin
    unique case ({1'b0, pp_off[0]} + {1'b0, pp_off[1]})
      2'd0:    pp_shifted = {64'd0, pp};
      2'd1:    pp_shifted = {32'd0, pp, 32'd0};
      default: pp_shifted = {pp, 64'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pp_valid <= 1'b0;
      done     <= 1'b0;
      cnt      <= '0;
    end else begin
      done     <= 1'b0;
      pp_valid <= 1'b0;
      if (start) begin
        a_reg <= a;
        b_reg <= b;
        prod  <= '0;
        cnt   <= '0;
        busy  <= 1'b1;
      end else begin
        if (busy && !cnt[2]) begin
          pp       <= a_half * b_half;
          pp_off   <= cnt[1:0];
          pp_valid <= 1'b1;
          cnt      <= cnt + 3'd1;
        end
        if (pp_valid) begin
          prod <= prod + pp_shifted;
          if (pp_off == 2'd3) begin
            done <= 1'b1;
            busy <= 1'b0;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ptp_div.sv =====
// Shared restoring divider: (num << sh) / den, one quotient bit per cycle.
// Depends on ptp_pkg for widths. A zero divisor gives an all-ones quotient.
`default_nettype none
module ptp_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [ptp_pkg::DIV_NUM_W-1:0]     num,
  input  wire logic [4:0]                        sh,
  input  wire logic [ptp_pkg::DIV_DEN_W-1:0]     den,
  output logic                                   done,
  output logic [ptp_pkg::DIV_Q_W-1:0]            quo
);

  localparam int CNT_W = $clog2(ptp_pkg::DIV_Q_W);

  logic [ptp_pkg::DIV_DEN_W-1:0] den_reg;
  logic [ptp_pkg::DIV_DEN_W-1:0] rem;
  logic [ptp_pkg::DIV_DEN_W:0]   rem_sh;
  logic [ptp_pkg::DIV_DEN_W:0]   rem_sub;
  logic                          ge;
  logic [CNT_W-1:0]              cnt;
  logic                          busy;

  assign rem_sh  = {rem, quo[ptp_pkg::DIV_Q_W-1]};
  assign ge      = rem_sh >= {1'b0, den_reg};
  assign rem_sub = rem_sh - {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo     <= ptp_pkg::DIV_Q_W'(num) << sh;
        rem     <= '0;
        den_reg <= den;
        cnt     <= '0;
        busy    <= 1'b1;
      end else if (busy) begin
        rem <= ge ? rem_sub[ptp_pkg::DIV_DEN_W-1:0] : rem_sh[ptp_pkg::DIV_DEN_W-1:0];
        quo <= {quo[ptp_pkg::DIV_Q_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ptp_pkg::DIV_Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire
